FILE: hdl/pfbl_pkg.sv
// Package for the packet descriptor queue with byte limit.
// Holds field widths, command and register codes, and the beat types.
// No dependencies; every other file in hdl uses it.
package pfbl_pkg;

   localparam int LEN_BITS       = 16;
   localparam int TAG_BITS       = 32;
   localparam int PKT_CNT_BITS   = 7;
   localparam int BYTE_CNT_BITS  = 22;
   localparam int TOTAL_BITS     = 32;
   localparam int DEPTH_DEFAULT  = 64;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_PACKETS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_BYTES   = 2'd1;

   localparam logic [PKT_CNT_BITS-1:0]  MAX_PACKETS_RESET = 7'd64;
   localparam logic [BYTE_CNT_BITS-1:0] MAX_BYTES_RESET   = 22'd0;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   typedef struct packed {
      logic                command;
      logic [LEN_BITS-1:0] pkt_len;
      logic [TAG_BITS-1:0] pkt_tag;
   } req_type;

   typedef struct packed {
      logic                     accepted;
      logic                     got_packet;
      logic [LEN_BITS-1:0]      out_len;
      logic [TAG_BITS-1:0]      out_tag;
      logic                     backpressure;
      logic                     bp_changed;
      logic [PKT_CNT_BITS-1:0]  packet_count;
      logic [BYTE_CNT_BITS-1:0] byte_count;
      logic [TOTAL_BITS-1:0]    enqueued_count;
      logic [TOTAL_BITS-1:0]    dequeued_count;
      logic [TOTAL_BITS-1:0]    rejected_count;
   } rsp_type;

   // A classified command as it waits between front and back.
   typedef struct packed {
      logic                is_dequeue;
      logic [LEN_BITS-1:0] pkt_len;
      logic [TAG_BITS-1:0] pkt_tag;
   } item_type;

   // One stored descriptor.
   typedef struct packed {
      logic [LEN_BITS-1:0] len;
      logic [TAG_BITS-1:0] tag;
   } slot_type;

   typedef struct packed {
      logic [PKT_CNT_BITS-1:0]  max_packets;
      logic [BYTE_CNT_BITS-1:0] max_bytes;
   } cfg_type;

   typedef enum logic [1:0] {
      BACK_EXEC  = 2'b01,
      BACK_FETCH = 2'b10
   } back_state_type;

endpackage

FILE: hdl/pfbl_front.sv
// Front end: takes request beats, classifies the command and holds them in
// a two-entry queue for the back end. Depends on pfbl_pkg.
module pfbl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pfbl_pkg::req_type  req_data,
   output logic               item_valid,
   input  logic               item_ready,
   output pfbl_pkg::item_type item_data
);

   pfbl_pkg::item_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push;
   logic               pop;
   pfbl_pkg::item_type classified;

   assign req_ready  = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item_data  = entry_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      classified.is_dequeue = (req_data.command == pfbl_pkg::CMD_DEQUEUE);
      classified.pkt_len    = req_data.pkt_len;
      classified.pkt_tag    = req_data.pkt_tag;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

FILE: hdl/pfbl_back.sv
// Back end: descriptor memory, occupancy and byte totals, backpressure and
// the running counters, with the response register. Depends on pfbl_pkg.
module pfbl_back #(
   parameter int DEPTH = pfbl_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  pfbl_pkg::cfg_type  cfg,
   input  logic               item_valid,
   output logic               item_ready,
   input  pfbl_pkg::item_type item_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pfbl_pkg::rsp_type  rsp_data
);

   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int BYTE_BITS = CNT_BITS + pfbl_pkg::LEN_BITS;
   localparam int LIM_BITS  = (CNT_BITS > pfbl_pkg::PKT_CNT_BITS) ?
                              CNT_BITS : pfbl_pkg::PKT_CNT_BITS;
   localparam int SUM_BITS  = (BYTE_BITS + 1 > pfbl_pkg::BYTE_CNT_BITS) ?
                              BYTE_BITS + 1 : pfbl_pkg::BYTE_CNT_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DEPTH - 1);
   localparam logic [LIM_BITS-1:0] DEPTH_LIM = LIM_BITS'(DEPTH);

   localparam int TB = pfbl_pkg::TOTAL_BITS;

   pfbl_pkg::slot_type mem [DEPTH];
   pfbl_pkg::slot_type rd_data_ff;

   pfbl_pkg::back_state_type state_ff, state_in;
   logic [IDX_BITS-1:0]  head_ff, head_in;
   logic [IDX_BITS-1:0]  tail_ff, tail_in;
   logic [CNT_BITS-1:0]  held_ff, held_in;
   logic [BYTE_BITS-1:0] bytes_ff, bytes_in;
   logic                 bp_ff, bp_in;
   logic [TB-1:0]        enq_tot_ff, enq_tot_in;
   logic [TB-1:0]        deq_tot_ff, deq_tot_in;
   logic [TB-1:0]        rej_tot_ff, rej_tot_in;
   logic                 out_valid_ff, out_valid_in;
   pfbl_pkg::rsp_type    out_data_ff, out_data_in;

   logic                 out_free;
   logic                 pop;
   logic                 mem_we;
   logic                 rd_en;
   pfbl_pkg::slot_type   wr_slot;
   logic [LIM_BITS-1:0]  limit;
   logic                 full_now;
   logic [SUM_BITS-1:0]  byte_sum;
   logic                 over_bytes;
   logic                 bp_now;

   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;
   assign out_free   = !out_valid_ff || rsp_ready;
   assign pop        = (state_ff == pfbl_pkg::BACK_EXEC) && item_valid && out_free;
   assign item_ready = pop;

   assign wr_slot.len = item_data.pkt_len;
   assign wr_slot.tag = item_data.pkt_tag;

   // Effective packet limit is the smaller of the register and the depth.
   assign limit = (LIM_BITS'(cfg.max_packets) < DEPTH_LIM) ?
                  LIM_BITS'(cfg.max_packets) : DEPTH_LIM;
   assign full_now   = LIM_BITS'(held_ff) >= limit;
   assign byte_sum   = SUM_BITS'(bytes_ff) + SUM_BITS'(item_data.pkt_len);
   assign over_bytes = (cfg.max_bytes != '0) && (byte_sum > SUM_BITS'(cfg.max_bytes));

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      held_in      = held_ff;
      bytes_in     = bytes_ff;
      bp_in        = bp_ff;
      enq_tot_in   = enq_tot_ff;
      deq_tot_in   = deq_tot_ff;
      rej_tot_in   = rej_tot_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_data_in  = out_data_ff;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      bp_now       = 1'b0;

      case (state_ff)
         pfbl_pkg::BACK_EXEC: begin
            if (pop) begin
               out_data_in = '0;
               if (!item_data.is_dequeue) begin
                  if (full_now || over_bytes) begin
                     rej_tot_in = rej_tot_ff + 1'b1;
                  end else begin
                     mem_we     = 1'b1;
                     tail_in    = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
                     held_in    = held_ff + 1'b1;
                     bytes_in   = bytes_ff + BYTE_BITS'(item_data.pkt_len);
                     enq_tot_in = enq_tot_ff + 1'b1;
                     out_data_in.accepted = 1'b1;
                  end
                  bp_now = LIM_BITS'(held_in) >= limit;
                  bp_in  = bp_now;
                  out_data_in.bp_changed = bp_now != bp_ff;
                  out_valid_in = 1'b1;
               end else if (held_ff == '0) begin
                  // Empty dequeue leaves the flag alone.
                  out_valid_in = 1'b1;
               end else begin
                  rd_en    = 1'b1;
                  head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
                  state_in = pfbl_pkg::BACK_FETCH;
               end
               out_data_in.backpressure   = bp_in;
               out_data_in.packet_count   = pfbl_pkg::PKT_CNT_BITS'(held_in);
               out_data_in.byte_count     = pfbl_pkg::BYTE_CNT_BITS'(bytes_in);
               out_data_in.enqueued_count = enq_tot_in;
               out_data_in.dequeued_count = deq_tot_in;
               out_data_in.rejected_count = rej_tot_in;
               if (rd_en) begin
                  out_data_in = out_data_ff;
               end
            end
         end
         pfbl_pkg::BACK_FETCH: begin
            // The response register is empty here: nothing else loads it.
            held_in    = held_ff - 1'b1;
            bytes_in   = bytes_ff - BYTE_BITS'(rd_data_ff.len);
            deq_tot_in = deq_tot_ff + 1'b1;
            bp_now     = LIM_BITS'(held_in) >= limit;
            bp_in      = bp_now;
            out_data_in.accepted       = 1'b0;
            out_data_in.got_packet     = 1'b1;
            out_data_in.out_len        = rd_data_ff.len;
            out_data_in.out_tag        = rd_data_ff.tag;
            out_data_in.backpressure   = bp_now;
            out_data_in.bp_changed     = bp_now != bp_ff;
            out_data_in.packet_count   = pfbl_pkg::PKT_CNT_BITS'(held_in);
            out_data_in.byte_count     = pfbl_pkg::BYTE_CNT_BITS'(bytes_in);
            out_data_in.enqueued_count = enq_tot_ff;
            out_data_in.dequeued_count = deq_tot_in;
            out_data_in.rejected_count = rej_tot_ff;
            out_valid_in = 1'b1;
            state_in     = pfbl_pkg::BACK_EXEC;
         end
         default: begin
            state_in = pfbl_pkg::BACK_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfbl_pkg::BACK_EXEC;
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         bytes_ff     <= '0;
         bp_ff        <= 1'b0;
         enq_tot_ff   <= '0;
         deq_tot_ff   <= '0;
         rej_tot_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         held_ff      <= held_in;
         bytes_ff     <= bytes_in;
         bp_ff        <= bp_in;
         enq_tot_ff   <= enq_tot_in;
         deq_tot_ff   <= deq_tot_in;
         rej_tot_ff   <= rej_tot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   // Descriptor memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= wr_slot;
      end
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

endmodule

FILE: hdl/packet_fifo_with_byte_limit.sv
// Top level of the packet descriptor queue with byte limit.
// Holds the two limit registers and joins pfbl_front and pfbl_back.
// Depends on pfbl_pkg, pfbl_front and pfbl_back.
//
// Usage
// -----
// The req channel carries one command per beat: enqueue a descriptor
// (length and tag) or dequeue the oldest one. Every request beat gives
// exactly one rsp beat, in order, reporting whether an enqueue was taken,
// the descriptor returned by a dequeue (zero when the queue was empty),
// the backpressure flag and whether it changed, the packets and bytes
// held afterwards, and wrapping totals of enqueues, dequeues and
// rejections. The csr channel writes the packet limit (index 0) and the
// byte limit (index 1, zero meaning no limit); it is always ready, other
// indexes are ignored, and it should only be written while the queue is
// quiet. A request beat passes through a two-entry front queue. When the
// back end takes an enqueue or an empty dequeue, it loads the response
// register directly; for a dequeue that returns a descriptor it first
// reads the slot memory into a register in the FETCH state, since the
// memory read is registered, and takes no new request until that response
// is loaded. A stalled rsp channel holds its beat in the response register
// while the front queue keeps taking requests until it is full. Reset
// empties the queue, clears all counters and loads the limits with 64
// packets and no byte limit; no memory clearing is needed.
module packet_fifo_with_byte_limit #(
   parameter int DEPTH = pfbl_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pfbl_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pfbl_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pfbl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pfbl_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   pfbl_pkg::cfg_type  cfg_ff, cfg_in;
   logic               item_valid;
   logic               item_ready;
   pfbl_pkg::item_type item_data;

   // Register writes are taken in any cycle.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pfbl_pkg::CSR_MAX_PACKETS: begin
               cfg_in.max_packets = pfbl_pkg::PKT_CNT_BITS'(csr_wdata);
            end
            pfbl_pkg::CSR_MAX_BYTES: begin
               cfg_in.max_bytes = pfbl_pkg::BYTE_CNT_BITS'(csr_wdata);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_packets <= pfbl_pkg::MAX_PACKETS_RESET;
         cfg_ff.max_bytes   <= pfbl_pkg::MAX_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfbl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item_data  (item_data)
   );

   pfbl_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item_data  (item_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
